FILE: sv/cemlp_pkg.sv
`default_nettype none
package cemlp_pkg;
    localparam int NEURONS_MAX = 32;
    localparam int FEATURES    = 4;
    localparam int RSD_BASE  = FEATURES;
    localparam int WOUT_BASE = 2 * FEATURES;
    localparam int BH_BASE   = 2 * FEATURES + NEURONS_MAX;
    localparam int WH_BASE   = 2 * FEATURES + 2 * NEURONS_MAX;

    localparam logic [2:0] REG_METHOD    = 3'd0;
    localparam logic [2:0] REG_FMODE     = 3'd1;
    localparam logic [2:0] REG_NCOUNT    = 3'd2;
    localparam logic [2:0] REG_OUT_BIAS  = 3'd3;
    localparam logic [2:0] REG_OUT_MEAN  = 3'd4;
    localparam logic [2:0] REG_OUT_SCALE = 3'd5;

    localparam logic CMD_LOAD = 1'b0;

    typedef enum logic [3:0] {
        S_IDLE, S_MEAN, S_RSD, S_NORM, S_NORM_ADD, S_BIAS, S_HW, S_HMAC,
        S_HDONE, S_WOUT, S_OMAC, S_Y, S_SCALE, S_FIN, S_OUT
    } t_state;

    typedef struct packed {
        logic        clr;
        logic [63:0] init;
        logic        mac;
        logic signed [31:0] a;
        logic signed [31:0] b;
    } t_mac_ctl;

    function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b,
                                              output logic ovf);
        logic [63:0] s;
        s = a + b;
        ovf = (a[63] == b[63]) && (s[63] != a[63]);
        if (ovf) begin
            sat_add64 = a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        end else begin
            sat_add64 = s;
        end
    endfunction

    function automatic logic [31:0] sat32(input logic [63:0] v, output logic ovf);
        ovf = (v[63:31] != {33{1'b0}}) && (v[63:31] != {33{1'b1}});
        if (ovf) begin
            sat32 = v[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            sat32 = v[31:0];
        end
    endfunction
endpackage
`default_nettype wire

FILE: sv/cluster_energy_mlp_estimator_core.sv
`default_nettype none
// Cluster energy estimator with one shared 32x32 multiply-accumulate unit.
// Input beats on s_axis carry either a coefficient load (cmd 0) or a cluster
// to estimate (cmd 1). A load is written in the cycle its beat is accepted,
// so loads can follow back to back, and it produces no output beat.
// An estimate reads coefficients from a 256-word store one per cycle and
// runs every multiply through the shared unit: it normalizes each feature,
// then runs each hidden neuron, or the output weights in linear mode, and
// applies the final scaling. s_axis_tready stays low while it runs.
// The result beat waits in an output register until m_axis_tready is high;
// the next input beat is accepted only after that.
// The configuration channel takes a register index and data at any cycle.
// Reset sets the registers to network mode, all features, 32 neurons, unit
// scale and zero bias and offset; the coefficient store is not cleared and
// must be loaded before the first estimate.
module cluster_energy_mlp_estimator_core
    import cemlp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // Bits from low: coef_index[7:0], coef_value[39:8], channel_width[51:40],
    // hit_count[63:52], adc_sum[87:64], time_width[103:88].
    input  wire logic [103:0] s_axis_tdata,
    // Bit 0: cmd.
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // Bits from low: energy[31:0].
    output logic [31:0]      m_axis_tdata,
    // Bit 0: saturated.
    output logic             m_axis_tuser,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);
    logic [31:0] r_store [256];
    logic [31:0] r_rd;
    logic [7:0]  r_addr, n_addr;

    logic        r_method, r_fmode;
    logic [5:0]  r_ncount;
    logic [31:0] r_out_bias, r_out_mean, r_out_scale;

    t_state r_state, n_state;
    logic [1:0]  r_f, n_f;
    logic [5:0]  r_n, n_n;
    logic [31:0] r_x [4];
    logic [31:0] r_nrm [4];
    logic [31:0] r_tmp, n_tmp;
    logic [63:0] r_oacc, n_oacc;
    logic        r_flag, n_flag;
    logic [31:0] r_energy, n_energy;
    logic [1:0]  r_wait, n_wait;

    t_mac_ctl    w_ctl;
    logic [63:0] w_acc;
    logic        w_ovf;
    logic [1:0]  w_nf_last;
    logic [5:0]  w_nn;
    logic        w_accept;
    logic [63:0] w_fl;
    logic [31:0] w_s32;
    logic        w_s_ovf;
    logic [31:0] w_n32;
    logic        w_n_ovf;
    logic [63:0] w_sum;
    logic        w_a_ovf;

    cemlp_mac u_mac (.i_clk(i_clk), .i_ctl(w_ctl), .o_acc(w_acc), .o_ovf(w_ovf));

    assign w_accept  = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign w_nf_last = r_fmode ? 2'(FEATURES - 1) : 2'd0;
    assign w_nn      = (r_ncount > 6'(NEURONS_MAX)) ? 6'(NEURONS_MAX) : r_ncount;
    assign w_fl      = {{16{w_acc[63]}}, w_acc[63:16]};

    always_ff @(posedge i_clk) begin
        if (w_accept && s_axis_tuser == CMD_LOAD) begin
            r_store[s_axis_tdata[7:0]] <= s_axis_tdata[39:8];
        end
        r_rd <= r_store[n_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_method    <= 1'b1;
            r_fmode     <= 1'b1;
            r_ncount    <= 6'd32;
            r_out_bias  <= '0;
            r_out_mean  <= '0;
            r_out_scale <= 32'd65536;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_METHOD:    r_method    <= i_cfg_data[0];
                REG_FMODE:     r_fmode     <= i_cfg_data[0];
                REG_NCOUNT:    r_ncount    <= i_cfg_data[5:0];
                REG_OUT_BIAS:  r_out_bias  <= i_cfg_data;
                REG_OUT_MEAN:  r_out_mean  <= i_cfg_data;
                REG_OUT_SCALE: r_out_scale <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_addr   <= n_addr;
        r_f      <= n_f;
        r_n      <= n_n;
        r_tmp    <= n_tmp;
        r_oacc   <= n_oacc;
        r_flag   <= n_flag;
        r_energy <= n_energy;
        r_wait   <= n_wait;
        if (w_accept) begin
            if (r_fmode) begin
                r_x[0] <= {20'd0, s_axis_tdata[51:40]};
                r_x[1] <= {20'd0, s_axis_tdata[63:52]};
                r_x[2] <= {8'd0, s_axis_tdata[87:64]};
                r_x[3] <= {16'd0, s_axis_tdata[103:88]};
            end else begin
                r_x[0] <= {8'd0, s_axis_tdata[87:64]};
                r_x[1] <= '0;
                r_x[2] <= '0;
                r_x[3] <= '0;
            end
        end
        if (r_state == S_NORM_ADD && r_wait == 2'd0) begin
            r_nrm[r_f] <= w_n32;
        end
    end

    // Next state and datapath sequencing.
    always_comb begin
        n_state  = r_state;
        n_addr   = r_addr;
        n_f      = r_f;
        n_n      = r_n;
        n_tmp    = r_tmp;
        n_oacc   = r_oacc;
        n_flag   = r_flag | w_ovf;
        n_energy = r_energy;
        n_wait   = (r_wait == 2'd0) ? 2'd0 : r_wait - 2'd1;
        w_s32    = sat32(w_fl, w_s_ovf);
        w_n32    = sat32(w_acc, w_n_ovf);
        w_sum    = sat_add64(r_oacc, w_acc, w_a_ovf);
        case (r_state)
            S_IDLE: begin
                if (w_accept && s_axis_tuser != CMD_LOAD) begin
                    n_state = S_MEAN;
                    n_f     = 2'd0;
                    n_addr  = 8'd0;
                    n_flag  = 1'b0;
                end
            end
            S_MEAN: begin
                n_tmp   = r_rd;
                n_state = S_RSD;
                n_addr  = 8'(RSD_BASE) + 8'(r_f);
            end
            S_RSD: begin
                n_state = S_NORM;
            end
            S_NORM: begin
                n_tmp   = r_rd;
                n_state = S_NORM_ADD;
                n_wait  = 2'd3;
            end
            S_NORM_ADD: begin
                if (r_wait == 2'd0) begin
                    n_flag = n_flag | w_n_ovf;
                    if (r_f == w_nf_last) begin
                        n_oacc = {{16{r_out_bias[31]}}, r_out_bias, 16'd0};
                        n_n    = '0;
                        n_f    = '0;
                        if (r_method && w_nn != 6'd0) begin
                            n_state = S_BIAS;
                            n_addr  = 8'(BH_BASE);
                        end else if (r_method) begin
                            n_state = S_Y;
                            n_wait  = 2'd1;
                        end else begin
                            n_state = S_WOUT;
                            n_addr  = 8'(WOUT_BASE);
                        end
                    end else begin
                        n_f     = r_f + 2'd1;
                        n_addr  = 8'(r_f) + 8'd1;
                        n_state = S_MEAN;
                    end
                end
            end
            S_BIAS: begin
                n_state = S_HW;
                n_addr  = 8'(WH_BASE) + 8'(r_n);
            end
            S_HW: begin
                n_state = S_HMAC;
            end
            S_HMAC: begin
                if (r_f == w_nf_last) begin
                    n_state = S_HDONE;
                    n_wait  = 2'd2;
                    n_addr  = 8'(WOUT_BASE) + 8'(r_n);
                end else begin
                    n_f    = r_f + 2'd1;
                    n_addr = 8'(WH_BASE) + 8'(NEURONS_MAX) * (8'(r_f) + 8'd1) + 8'(r_n);
                end
            end
            S_HDONE: begin
                if (r_wait == 2'd0) begin
                    n_flag  = r_flag | w_s_ovf;
                    n_tmp   = w_s32[31] ? 32'd0 : w_s32;
                    n_state = S_OMAC;
                    n_wait  = 2'd2;
                end
            end
            S_OMAC: begin
                if (r_wait == 2'd0) begin
                    n_oacc = r_method ? w_sum : w_acc;
                    if (r_method) begin
                        n_flag = n_flag | w_a_ovf;
                    end
                    n_f    = '0;
                    if (r_n + 6'd1 == w_nn) begin
                        n_state = S_Y;
                        n_wait  = 2'd1;
                    end else begin
                        n_n     = r_n + 6'd1;
                        n_addr  = 8'(BH_BASE) + 8'(r_n) + 8'd1;
                        n_state = S_BIAS;
                    end
                end
            end
            S_WOUT: begin
                if (r_f == w_nf_last) begin
                    n_state = S_OMAC;
                    n_wait  = 2'd2;
                    n_n     = w_nn - 6'd1;
                end else begin
                    n_f    = r_f + 2'd1;
                    n_addr = 8'(WOUT_BASE) + 8'(r_f) + 8'd1;
                end
            end
            S_Y: begin
                if (r_wait == 2'd0) begin
                    n_tmp   = sat32({{16{r_oacc[63]}}, r_oacc[63:16]}, w_s_ovf);
                    n_flag  = r_flag | w_s_ovf;
                    n_state = S_SCALE;
                    n_wait  = 2'd2;
                end
            end
            S_SCALE: begin
                if (r_wait == 2'd0) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_flag   = r_flag | w_ovf | w_s_ovf;
                n_energy = w_s32;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // MAC control per state.
    always_comb begin
        w_ctl = '0;
        case (r_state)
            S_NORM: begin
                w_ctl.clr  = 1'b1;
                w_ctl.init = {{32{r_rd[31]}}, r_rd};
                w_ctl.mac  = 1'b1;
                w_ctl.a    = $signed(~r_tmp);
                w_ctl.b    = $signed(r_rd);
            end
            S_NORM_ADD: begin
                if (r_wait == 2'd2) begin
                    w_ctl.clr  = 1'b1;
                    w_ctl.init = {{16{w_acc[63]}}, w_acc[63:16]};
                    w_ctl.mac  = 1'b1;
                    w_ctl.a    = $signed(r_x[r_f]);
                    w_ctl.b    = $signed(r_tmp);
                end else if (r_wait == 2'd0 && r_f == w_nf_last && !r_method) begin
                    w_ctl.clr  = 1'b1;
                    w_ctl.init = {{16{r_out_bias[31]}}, r_out_bias, 16'd0};
                end
            end
            S_BIAS: begin
                w_ctl.clr  = 1'b1;
                w_ctl.init = {{16{r_rd[31]}}, r_rd, 16'd0};
            end
            S_HMAC: begin
                w_ctl.mac = 1'b1;
                w_ctl.a   = $signed(r_nrm[r_f]);
                w_ctl.b   = $signed(r_rd);
            end
            S_HDONE: begin
                if (r_wait == 2'd0) begin
                    w_ctl.clr = 1'b1;
                end
            end
            S_OMAC: begin
                if (r_wait == 2'd2 && r_method) begin
                    w_ctl.mac = 1'b1;
                    w_ctl.a   = $signed(r_tmp);
                    w_ctl.b   = $signed(r_rd);
                end
            end
            S_WOUT: begin
                w_ctl.mac = 1'b1;
                w_ctl.a   = $signed(r_nrm[r_f]);
                w_ctl.b   = $signed(r_rd);
            end
            S_Y: begin
                if (r_wait == 2'd1) begin
                    w_ctl.clr = 1'b1;
                end
            end
            S_SCALE: begin
                if (r_wait == 2'd2) begin
                    w_ctl.clr  = 1'b1;
                    w_ctl.init = {{16{r_out_mean[31]}}, r_out_mean, 16'd0};
                    w_ctl.mac  = 1'b1;
                    w_ctl.a    = $signed(r_tmp);
                    w_ctl.b    = $signed(r_out_scale);
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = r_energy;
    assign m_axis_tuser  = r_flag;

    ap_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !s_axis_tready) else $error("ready while busy");
    ap_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result dropped");
    ap_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && s_axis_tuser != CMD_LOAD) |=> (r_state == S_MEAN))
        else $error("estimate not started");
endmodule
`default_nettype wire

FILE: sv/cemlp_mac.sv
`default_nettype none
module cemlp_mac
    import cemlp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire t_mac_ctl    i_ctl,
    output logic [63:0]      o_acc,
    output logic             o_ovf
);
    logic signed [63:0] r_prod;
    logic               r_pv;
    logic [63:0]        r_acc;
    logic               r_ovf;
    logic [63:0]        n_acc;
    logic               n_ovf;

    always_comb begin
        n_acc = sat_add64(r_acc, r_prod, n_ovf);
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_ctl.a * i_ctl.b;
        r_pv   <= i_ctl.mac;
        if (i_ctl.clr) begin
            r_acc <= i_ctl.init;
            r_ovf <= 1'b0;
        end else if (r_pv) begin
            r_acc <= n_acc;
            r_ovf <= n_ovf;
        end else begin
            r_ovf <= 1'b0;
        end
    end

    assign o_acc = r_acc;
    assign o_ovf = r_ovf;
endmodule
`default_nettype wire
